// ----- hw/rtl/psu_pkg.sv -----
// Shared constants, types and the Paeth predictor for the PNG scanline unfilter.
// No dependencies; every other file of the block imports this package.
package psu_pkg;

    localparam int MAX_LINE_BYTES_DEF  = 16384;
    localparam int MAX_PIXEL_BYTES_DEF = 6;

    localparam int LINE_BYTES_W = 15;
    localparam int PIXEL_BYTES_W = 3;
    localparam int CFG_DATA_W = 15;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_LINE_BYTES  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_BYTES = 1'd1;

    localparam logic [2:0] FILT_NONE  = 3'd0;
    localparam logic [2:0] FILT_SUB   = 3'd1;
    localparam logic [2:0] FILT_UP    = 3'd2;
    localparam logic [2:0] FILT_AVG   = 3'd3;
    localparam logic [2:0] FILT_PAETH = 3'd4;

    localparam logic [1:0] KIND_TYPE = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] filter;
        logic       first_row;
        logic       last;
    } psu_ctl_t;

    function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
        logic [9:0] pa;
        logic [9:0] pb;
        logic [9:0] pc;
        logic [9:0] ab;
        logic [9:0] cc;
        logic [7:0] pick;
        pa = (b > c) ? 10'(b - c) : 10'(c - b);
        pb = (a > c) ? 10'(a - c) : 10'(c - a);
        ab = 10'(a) + 10'(b);
        cc = 10'(c) + 10'(c);
        pc = (ab > cc) ? (ab - cc) : (cc - ab);
        if (pa <= pb && pa <= pc)
        begin
            pick = a;
        end
        else if (pb <= pc)
        begin
            pick = b;
        end
        else
        begin
            pick = c;
        end
        return pick;
    endfunction

endpackage

// ----- hw/rtl/png_scanline_unfilter_top.sv -----
// Top level of the PNG scanline unfilter: configuration registers and block wiring.
// Depends on psu_pkg, psu_front, psu_line_mem and psu_recon.
//
//   channel   signals                                       direction
//   input     in_valid/in_ready, data_byte, image_start     in
//   output    out_valid/out_ready, pixel_byte, line_end,    out
//             bad_filter
//   config    cfg_we, cfg_index, cfg_data                   in
//
// One item is taken per cycle while the output is not stalled; an accepted data byte
// waits in the reconstruction stage for the registered line store read, then enters the output register.
// Reset leaves the block waiting for a filter type byte on the first row.
// A stalled output holds a data or error item in the reconstruction stage, which then holds the input.
// The line store needs no clearing after reset.
module png_scanline_unfilter_top #(
    parameter int MaxLineBytes = psu_pkg::MAX_LINE_BYTES_DEF,
    parameter int MaxPixelBytes = psu_pkg::MAX_PIXEL_BYTES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       data_byte,
    input  logic                             image_start,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [7:0]                       pixel_byte,
    output logic                             line_end,
    output logic                             bad_filter,
    input  logic                             cfg_we,
    input  logic [psu_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [psu_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import psu_pkg::*;

    localparam int IdxW = (MaxLineBytes > 1) ? $clog2(MaxLineBytes) : 1;
    localparam int LenW = $clog2(MaxLineBytes + 1);

    logic [LINE_BYTES_W-1:0]  line_bytes_reg;
    logic [PIXEL_BYTES_W-1:0] pixel_bytes_reg;

    logic            stage_free;
    logic            stage_load;
    psu_ctl_t        stage_ctl;
    logic            rd_en;
    logic [IdxW-1:0] rd_addr;
    logic [7:0]      rd_data;
    logic            wr_en;
    logic [IdxW-1:0] wr_addr;
    logic [7:0]      wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_bytes_reg  <= LINE_BYTES_W'(1);
            pixel_bytes_reg <= PIXEL_BYTES_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LINE_BYTES:  line_bytes_reg  <= LINE_BYTES_W'(cfg_data);
                CFG_PIXEL_BYTES: pixel_bytes_reg <= cfg_data[PIXEL_BYTES_W-1:0];
                default:         ;
            endcase
        end
    end

    psu_front #(
        .MaxLineBytes (MaxLineBytes),
        .IdxW         (IdxW),
        .LenW         (LenW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .image_start (image_start),
        .line_bytes  (line_bytes_reg),
        .stage_free  (stage_free),
        .stage_load  (stage_load),
        .stage_ctl   (stage_ctl),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr)
    );

    psu_line_mem #(
        .MaxLineBytes (MaxLineBytes),
        .IdxW         (IdxW)
    ) u_line_mem (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    psu_recon #(
        .MaxLineBytes  (MaxLineBytes),
        .MaxPixelBytes (MaxPixelBytes),
        .IdxW          (IdxW)
    ) u_recon (
        .clk             (clk),
        .rst_n           (rst_n),
        .stage_load      (stage_load),
        .stage_ctl       (stage_ctl),
        .data_byte       (data_byte),
        .rd_addr         (rd_addr),
        .stage_free      (stage_free),
        .bytes_per_pixel (pixel_bytes_reg),
        .rd_data         (rd_data),
        .wr_en           (wr_en),
        .wr_addr         (wr_addr),
        .wr_data         (wr_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .pixel_byte      (pixel_byte),
        .line_end        (line_end),
        .bad_filter      (bad_filter)
    );

endmodule

// ----- hw/rtl/psu_line_mem.sv -----
// Line store of the unfilter: one synchronous RAM holding the previous scanline.
// One write port and one read port with registered read data; uses psu_pkg.
module psu_line_mem #(
    parameter int MaxLineBytes = psu_pkg::MAX_LINE_BYTES_DEF,
    parameter int IdxW = (MaxLineBytes > 1) ? $clog2(MaxLineBytes) : 1
) (
    input  logic            clk,
    input  logic            we,
    input  logic [IdxW-1:0] waddr,
    input  logic [7:0]      wdata,
    input  logic            re,
    input  logic [IdxW-1:0] raddr,
    output logic [7:0]      rdata
);
    import psu_pkg::*;

    logic [7:0] mem [MaxLineBytes];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hw/rtl/psu_front.sv -----
// Input side of the unfilter: accepts items, tracks line position, row and error state.
// Classifies each byte and issues the line store read; uses psu_pkg.
module psu_front #(
    parameter int MaxLineBytes = psu_pkg::MAX_LINE_BYTES_DEF,
    parameter int IdxW = (MaxLineBytes > 1) ? $clog2(MaxLineBytes) : 1,
    parameter int LenW = $clog2(MaxLineBytes + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [7:0]                        data_byte,
    input  logic                              image_start,
    input  logic [psu_pkg::LINE_BYTES_W-1:0]  line_bytes,
    input  logic                              stage_free,
    output logic                              stage_load,
    output psu_pkg::psu_ctl_t                 stage_ctl,
    output logic                              rd_en,
    output logic [IdxW-1:0]                   rd_addr
);
    import psu_pkg::*;

    logic            await_reg;
    logic            await_next;
    logic [IdxW-1:0] pos_reg;
    logic [IdxW-1:0] pos_next;
    logic [2:0]      filter_reg;
    logic [2:0]      filter_next;
    logic            first_reg;
    logic            first_next;
    logic            err_reg;
    logic            err_next;

    logic            accept;
    logic            eff_await;
    logic            eff_first;
    logic            eff_err;
    logic [IdxW-1:0] eff_pos;
    logic [LenW-1:0] len_eff;
    logic            last;

    always_comb
    begin
        if (line_bytes == '0)
        begin
            len_eff = LenW'(1);
        end
        else if (32'(line_bytes) > 32'(MaxLineBytes))
        begin
            len_eff = LenW'(MaxLineBytes);
        end
        else
        begin
            len_eff = LenW'(line_bytes);
        end
    end

    assign in_ready  = stage_free;
    assign accept    = in_valid && in_ready;
    assign eff_await = image_start || await_reg;
    assign eff_first = image_start || first_reg;
    assign eff_err   = !image_start && err_reg;
    assign eff_pos   = image_start ? '0 : pos_reg;
    assign last      = (LenW'(eff_pos) + LenW'(1)) >= len_eff;

    assign rd_addr = eff_pos;
    assign rd_en   = accept && !eff_err && !eff_await;

    always_comb
    begin
        await_next          = await_reg;
        pos_next            = pos_reg;
        filter_next         = filter_reg;
        first_next          = first_reg;
        err_next            = err_reg;
        stage_load          = 1'b0;
        stage_ctl.kind      = KIND_DATA;
        stage_ctl.filter    = filter_reg;
        stage_ctl.first_row = eff_first;
        stage_ctl.last      = last;
        if (accept)
        begin
            await_next = eff_await;
            pos_next   = eff_pos;
            first_next = eff_first;
            err_next   = eff_err;
            if (!eff_err)
            begin
                stage_load = 1'b1;
                if (eff_await)
                begin
                    if (data_byte > 8'(FILT_PAETH))
                    begin
                        stage_ctl.kind = KIND_ERR;
                        err_next       = 1'b1;
                    end
                    else
                    begin
                        stage_ctl.kind = KIND_TYPE;
                        filter_next    = data_byte[2:0];
                        await_next     = 1'b0;
                        pos_next       = '0;
                    end
                end
                else if (last)
                begin
                    await_next = 1'b1;
                    pos_next   = '0;
                    first_next = 1'b0;
                end
                else
                begin
                    pos_next = eff_pos + IdxW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            await_reg  <= 1'b1;
            pos_reg    <= '0;
            filter_reg <= FILT_NONE;
            first_reg  <= 1'b1;
            err_reg    <= 1'b0;
        end
        else
        begin
            await_reg  <= await_next;
            pos_reg    <= pos_next;
            filter_reg <= filter_next;
            first_reg  <= first_next;
            err_reg    <= err_next;
        end
    end

endmodule

// ----- hw/rtl/psu_recon.sv -----
// Reconstruction stage of the unfilter: prediction, line store write-back and output register.
// Holds the left and above-left byte histories; uses psu_pkg.
module psu_recon #(
    parameter int MaxLineBytes = psu_pkg::MAX_LINE_BYTES_DEF,
    parameter int MaxPixelBytes = psu_pkg::MAX_PIXEL_BYTES_DEF,
    parameter int IdxW = (MaxLineBytes > 1) ? $clog2(MaxLineBytes) : 1
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               stage_load,
    input  psu_pkg::psu_ctl_t                  stage_ctl,
    input  logic [7:0]                         data_byte,
    input  logic [IdxW-1:0]                    rd_addr,
    output logic                               stage_free,
    input  logic [psu_pkg::PIXEL_BYTES_W-1:0]  bytes_per_pixel,
    input  logic [7:0]                         rd_data,
    output logic                               wr_en,
    output logic [IdxW-1:0]                    wr_addr,
    output logic [7:0]                         wr_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [7:0]                         pixel_byte,
    output logic                               line_end,
    output logic                               bad_filter
);
    import psu_pkg::*;

    localparam int HistW = (MaxPixelBytes > 1) ? $clog2(MaxPixelBytes) : 1;

    logic            s1_valid_reg;
    logic            s1_valid_next;
    psu_ctl_t        s1_ctl_reg;
    logic [7:0]      s1_byte_reg;
    logic [IdxW-1:0] s1_idx_reg;
    logic [7:0]      left_reg [MaxPixelBytes];
    logic [7:0]      up_reg [MaxPixelBytes];
    logic            out_valid_reg;
    logic            out_valid_next;
    logic [7:0]      pixel_reg;
    logic            line_end_reg;
    logic            bad_reg;

    logic            s1_go;
    logic [HistW-1:0] sel;
    logic [7:0]      a;
    logic [7:0]      b;
    logic [7:0]      c;
    logic [8:0]      ab_sum;
    logic [7:0]      pred;
    logic [7:0]      val;

    always_comb
    begin
        if (bytes_per_pixel == '0)
        begin
            sel = '0;
        end
        else if (32'(bytes_per_pixel) > 32'(MaxPixelBytes))
        begin
            sel = HistW'(MaxPixelBytes - 1);
        end
        else
        begin
            sel = HistW'(bytes_per_pixel - PIXEL_BYTES_W'(1));
        end
    end

    assign a      = left_reg[sel];
    assign b      = s1_ctl_reg.first_row ? 8'd0 : rd_data;
    assign c      = s1_ctl_reg.first_row ? 8'd0 : up_reg[sel];
    assign ab_sum = 9'(a) + 9'(b);

    always_comb
    begin
        unique case (s1_ctl_reg.filter)
            FILT_NONE:  pred = 8'd0;
            FILT_SUB:   pred = a;
            FILT_UP:    pred = b;
            FILT_AVG:   pred = ab_sum[8:1];
            FILT_PAETH: pred = paeth_pick(a, b, c);
            default:    pred = 8'd0;
        endcase
    end

    assign val = s1_byte_reg + pred;

    assign s1_go = s1_valid_reg
                && (s1_ctl_reg.kind == KIND_TYPE || !out_valid_reg || out_ready);
    assign stage_free = !s1_valid_reg || s1_go;

    assign wr_en   = s1_go && s1_ctl_reg.kind == KIND_DATA;
    assign wr_addr = s1_idx_reg;
    assign wr_data = val;

    assign s1_valid_next = stage_load || (s1_valid_reg && !s1_go);

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (s1_go && s1_ctl_reg.kind != KIND_TYPE)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < MaxPixelBytes; k++)
            begin
                left_reg[k] <= 8'd0;
                up_reg[k]   <= 8'd0;
            end
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_go && s1_ctl_reg.kind == KIND_TYPE)
            begin
                for (int k = 0; k < MaxPixelBytes; k++)
                begin
                    left_reg[k] <= 8'd0;
                    up_reg[k]   <= 8'd0;
                end
            end
            else if (wr_en)
            begin
                for (int k = MaxPixelBytes - 1; k > 0; k--)
                begin
                    left_reg[k] <= left_reg[k-1];
                    up_reg[k]   <= up_reg[k-1];
                end
                left_reg[0] <= val;
                up_reg[0]   <= b;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_load)
        begin
            s1_ctl_reg  <= stage_ctl;
            s1_byte_reg <= data_byte;
            s1_idx_reg  <= rd_addr;
        end
        if (s1_go && s1_ctl_reg.kind != KIND_TYPE)
        begin
            if (s1_ctl_reg.kind == KIND_ERR)
            begin
                pixel_reg    <= 8'd0;
                line_end_reg <= 1'b0;
                bad_reg      <= 1'b1;
            end
            else
            begin
                pixel_reg    <= val;
                line_end_reg <= s1_ctl_reg.last;
                bad_reg      <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_byte = pixel_reg;
    assign line_end   = line_end_reg;
    assign bad_filter = bad_reg;

endmodule
